/* sv/tkh_pkg.sv */
package tkh_pkg;

  localparam int unsigned TopK    = 20;
  localparam int unsigned IdxW    = $clog2(TopK);
  localparam int unsigned FillW   = $clog2(TopK + 1);
  localparam int unsigned KeyW    = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned QDepth  = 2;

  localparam logic ModeOffer = 1'b0;
  localparam logic ModeDump  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [KeyW-1:0]   entry_key;
    logic [CountW-1:0] entry_count;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0]   out_key;
    logic [CountW-1:0] out_count;
    logic              out_valid;
    logic              out_last;
  } out_item_t;

  typedef struct packed {
    logic              is_dump;
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
  } cmd_t;

endpackage

/* sv/tkh_if.sv */
interface tkh_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [tkh_pkg::KeyW-1:0]   entry_key;
  logic [tkh_pkg::CountW-1:0] entry_count;
  modport source (output valid, mode, entry_key, entry_count, input ready);
  modport sink   (input valid, mode, entry_key, entry_count, output ready);
endinterface

interface tkh_out_if;
  logic                       valid;
  logic                       ready;
  logic [tkh_pkg::KeyW-1:0]   out_key;
  logic [tkh_pkg::CountW-1:0] out_count;
  logic                       out_valid;
  logic                       out_last;
  modport source (output valid, out_key, out_count, out_valid, out_last, input ready);
  modport sink   (input valid, out_key, out_count, out_valid, out_last, output ready);
endinterface

/* sv/tkh_front.sv */
// Accepts items and queues them as commands for the engine.
module tkh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  tkh_in_if.sink        in_i,
  output tkh_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);

  tkh_pkg::cmd_t fifo_q [tkh_pkg::QDepth];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{is_dump: (in_i.mode == tkh_pkg::ModeDump),
                            key: in_i.entry_key, count: in_i.entry_count};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_i.ready) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

/* sv/tkh_engine.sv */
// Heap store and sequencer: fill, bottom-up build, replace+sift, dump.
// Store is a memory read one address per cycle with registered read data.
module tkh_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tkh_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  tkh_out_if.source     out_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SBuild = 4'd1;  // start sift at build_i
  localparam logic [3:0] SRdPos = 4'd2;  // read pos entry
  localparam logic [3:0] SRdL   = 4'd3;  // read left child
  localparam logic [3:0] SRdR   = 4'd4;  // read right child
  localparam logic [3:0] SCmp   = 4'd5;  // pick child, compare
  localparam logic [3:0] SDump  = 4'd6;  // read next entry for dump
  localparam logic [3:0] SDOut  = 4'd7;  // present dump entry
  localparam logic [3:0] SRoot  = 4'd8;  // compare offer with root
  localparam logic [3:0] SEmpty = 4'd9;

  localparam int unsigned IdxW = tkh_pkg::IdxW;
  localparam int unsigned CW   = IdxW + 2;  // child index room

  logic [tkh_pkg::KeyW-1:0]   mem_key   [tkh_pkg::TopK];
  logic [tkh_pkg::CountW-1:0] mem_count [tkh_pkg::TopK];
  logic [tkh_pkg::KeyW-1:0]   rd_key_q;
  logic [tkh_pkg::CountW-1:0] rd_count_q;

  logic [3:0]                 state_q, state_d;
  logic [tkh_pkg::FillW-1:0]  fill_q, fill_d;
  logic                       built_q, built_d;
  logic [IdxW-1:0]            build_i_q, build_i_d;
  logic [IdxW-1:0]            pos_q, pos_d;
  logic [IdxW-1:0]            ptr_q, ptr_d;
  logic [tkh_pkg::KeyW-1:0]   hold_key_q, hold_key_d;
  logic [tkh_pkg::CountW-1:0] hold_cnt_q, hold_cnt_d;
  logic [tkh_pkg::KeyW-1:0]   lkey_q, lkey_d;
  logic [tkh_pkg::CountW-1:0] lcnt_q, lcnt_d;
  logic                       offer_q, offer_d;  // replace pending after build
  tkh_pkg::cmd_t              cmd_q, cmd_d;
  tkh_pkg::out_item_t         res_q, res_d;
  logic                       res_v_q, res_v_d;

  logic                       rd_en, wr_en;
  logic [IdxW-1:0]            rd_addr, wr_addr;
  logic [tkh_pkg::KeyW-1:0]   wr_key;
  logic [tkh_pkg::CountW-1:0] wr_cnt;
  logic [CW-1:0]              lc, rc;
  logic                       res_free;

  assign lc       = {1'b0, pos_q, 1'b1};
  assign rc       = lc + CW'(1);
  assign res_free = !res_v_q || out_o.ready;
  assign cmd_ready_o = (state_q == SIdle);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_key[wr_addr]   <= wr_key;
      mem_count[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_key_q   <= mem_key[rd_addr];
      rd_count_q <= mem_count[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;  fill_d = fill_q;  built_d = built_q;
    build_i_d = build_i_q;  pos_d = pos_q;  ptr_d = ptr_q;
    hold_key_d = hold_key_q;  hold_cnt_d = hold_cnt_q;
    lkey_d = lkey_q;  lcnt_d = lcnt_q;  offer_d = offer_q;  cmd_d = cmd_q;
    res_d = res_q;  res_v_d = res_v_q && !out_o.ready;
    rd_en = 1'b0;  rd_addr = pos_q;
    wr_en = 1'b0;  wr_addr = pos_q;  wr_key = hold_key_q;  wr_cnt = hold_cnt_q;
    unique case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          if (cmd_i.is_dump) begin
            ptr_d = '0;
            state_d = (fill_q == '0) ? SEmpty : SDump;
          end else if (fill_q != tkh_pkg::FillW'(tkh_pkg::TopK)) begin
            wr_en = 1'b1;  wr_addr = IdxW'(fill_q);
            wr_key = cmd_i.key;  wr_cnt = cmd_i.count;
            fill_d = fill_q + 1'b1;
          end else if (!built_q) begin
            offer_d = 1'b1;
            build_i_d = IdxW'((tkh_pkg::TopK - 1) / 2);
            state_d = SBuild;
          end else begin
            rd_en = 1'b1;  rd_addr = '0;
            state_d = SRoot;
          end
        end
      end
      SBuild: begin
        pos_d = build_i_q;  rd_en = 1'b1;  rd_addr = build_i_q;
        state_d = SRdPos;
      end
      SRdPos: begin
        hold_key_d = rd_key_q;  hold_cnt_d = rd_count_q;
        state_d = SRdL;
      end
      SRdL: begin
        if (lc < CW'(tkh_pkg::TopK)) begin
          rd_en = 1'b1;  rd_addr = IdxW'(lc);
          state_d = SRdR;
        end else begin
          wr_en = 1'b1;  // place held entry, sift done
          if (offer_q) begin
            if (build_i_q == '0) begin
              built_d = 1'b1;  offer_d = 1'b0;
              rd_en = 1'b1;  rd_addr = '0;
              state_d = SRoot;
            end else begin
              build_i_d = build_i_q - 1'b1;
              state_d = SBuild;
            end
          end else begin
            state_d = SIdle;
          end
        end
      end
      SRdR: begin
        lkey_d = rd_key_q;  lcnt_d = rd_count_q;
        if (rc < CW'(tkh_pkg::TopK)) begin
          rd_en = 1'b1;  rd_addr = IdxW'(rc);
        end
        state_d = SCmp;
      end
      SCmp: begin
        // right taken only if strictly smaller than left
        if (rc < CW'(tkh_pkg::TopK) && lcnt_q > rd_count_q) begin
          if (hold_cnt_q > rd_count_q) begin
            wr_en = 1'b1;  wr_key = rd_key_q;  wr_cnt = rd_count_q;
            pos_d = IdxW'(rc);  state_d = SRdL;
          end else begin
            wr_en = 1'b1;  state_d = SRdL;  pos_d = pos_q;
            state_d = offer_q ? SRdL : SRdL;
          end
        end else if (hold_cnt_q > lcnt_q) begin
          wr_en = 1'b1;  wr_key = lkey_q;  wr_cnt = lcnt_q;
          pos_d = IdxW'(lc);  state_d = SRdL;
        end else begin
          wr_en = 1'b1;
          state_d = SRdL;
        end
        // stop case: finish the sift here when the held entry stays at pos
        if (!(wr_en && (pos_d != pos_q))) begin
          // held entry already written at pos; finish sift
          if (offer_q) begin
            if (build_i_q == '0) begin
              built_d = 1'b1;  offer_d = 1'b0;
              rd_en = 1'b1;  rd_addr = '0;
              state_d = SRoot;
            end else begin
              build_i_d = build_i_q - 1'b1;
              state_d = SBuild;
            end
          end else begin
            state_d = SIdle;
          end
        end
      end
      SRoot: begin
        if (cmd_q.count > rd_count_q) begin
          hold_key_d = cmd_q.key;  hold_cnt_d = cmd_q.count;
          pos_d = '0;  state_d = SRdL;
        end else begin
          state_d = SIdle;
        end
      end
      SDump: begin
        rd_en = 1'b1;  rd_addr = ptr_q;
        state_d = SDOut;
      end
      SDOut: begin
        if (res_free) begin
          res_v_d = 1'b1;
          res_d = '{out_key: rd_key_q, out_count: rd_count_q, out_valid: 1'b1,
                    out_last: (tkh_pkg::FillW'(ptr_q) + 1'b1 == fill_q)};
          if (tkh_pkg::FillW'(ptr_q) + 1'b1 == fill_q) begin
            state_d = SIdle;
          end else begin
            ptr_d = ptr_q + 1'b1;  state_d = SDump;
          end
        end
      end
      SEmpty: begin
        if (res_free) begin
          res_v_d = 1'b1;
          res_d = '{out_key: '0, out_count: '0, out_valid: 1'b0, out_last: 1'b1};
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    build_i_q <= build_i_d;  pos_q <= pos_d;  ptr_q <= ptr_d;
    hold_key_q <= hold_key_d;  hold_cnt_q <= hold_cnt_d;
    lkey_q <= lkey_d;  lcnt_q <= lcnt_d;  cmd_q <= cmd_d;  res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;  fill_q <= '0;  built_q <= 1'b0;
      offer_q <= 1'b0;  res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;  fill_q <= fill_d;  built_q <= built_d;
      offer_q <= offer_d;  res_v_q <= res_v_d;
    end
  end

  assign out_o.valid     = res_v_q;
  assign out_o.out_key   = res_q.out_key;
  assign out_o.out_count = res_q.out_count;
  assign out_o.out_valid = res_q.out_valid;
  assign out_o.out_last  = res_q.out_last;

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= tkh_pkg::FillW'(tkh_pkg::TopK)) else $error("fill over capacity");
  a_built_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> fill_q == tkh_pkg::FillW'(tkh_pkg::TopK)) else $error("heap before full");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !out_o.ready |=> res_v_q && $stable(res_q)) else $error("result lost");

endmodule

/* sv/top_k_min_heap_selector.sv */
// Channel | Dir | Fields
// in_i    | in  | mode, entry_key, entry_count
// out_o   | out | out_key, out_count, out_valid, out_last
//
// Filling offer: written straight into the store. Heap offer: compared with the
// root and dropped unless larger; a replacement sifts down, comparing with the
// smaller child at each level. The first offer after fill runs a bottom-up build
// of 10 sifts first, then the offer. Dump: each entry is read, then presented.
// A 2-entry queue decouples input from the engine.
// Reset empties the store; output stalls hold the engine, not the queue.
module top_k_min_heap_selector (
  input logic        clk_i,
  input logic        rst_ni,
  tkh_in_if.sink     in_i,
  tkh_out_if.source  out_o
);

  tkh_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  tkh_front u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  tkh_engine u_engine (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .out_o
  );

endmodule
